FILE: design/round_robin_event_dispatcher_assert.svh
// Assertion macros for the event dispatcher
`ifndef ROUND_ROBIN_EVENT_DISPATCHER_ASSERT_SVH
`define ROUND_ROBIN_EVENT_DISPATCHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication checked on every clock after reset
`define RRED_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock after reset
`define RRED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RRED_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RRED_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: design/rred_pkg.sv
package rred_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 16;
    localparam int SRC_W       = 3;
    localparam int MASK_W      = 8;
    localparam int RC_W        = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NCNT_W      = $clog2(NUM_SOURCES + 1);
    localparam int SLOT_W      = $clog2(NUM_SOURCES);

    localparam logic [2:0] STAT_ACCEPTED   = 3'd0;
    localparam logic [2:0] STAT_INVALID    = 3'd1;
    localparam logic [2:0] STAT_FULL       = 3'd2;
    localparam logic [2:0] STAT_DISPATCHED = 3'd3;
    localparam logic [2:0] STAT_DONE       = 3'd4;

    localparam logic KIND_POST     = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef struct packed {
        logic [SRC_W-1:0]     src;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } mod_stat_t;

    // Count the present sources
    function automatic logic [NCNT_W-1:0] count_sources(input logic [NUM_SOURCES-1:0] bits);
        logic [NCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            n = n + NCNT_W'(bits[i]);
        end
        return n;
    endfunction

    // Map a slot to the source index of the slot-th set bit
    function automatic logic [SRC_W-1:0] pick_source(input logic [NUM_SOURCES-1:0] bits,
                                                     input logic [SLOT_W-1:0] slot);
        logic [NCNT_W-1:0] seen;
        logic [SRC_W-1:0]  r;
        seen = '0;
        r = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (bits[i]) begin
                if (seen == NCNT_W'(slot)) begin
                    r = SRC_W'(i);
                end
                seen = seen + 1'b1;
            end
        end
        return r;
    endfunction

endpackage

FILE: design/rred_queue_ram.sv
module rred_queue_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [rred_pkg::ADDR_W-1:0] waddr,
    input  rred_pkg::entry_t           wdata,
    input  logic [rred_pkg::ADDR_W-1:0] raddr,
    output rred_pkg::entry_t           rdata
);
    import rred_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/rred_mod_unit.sv
module rred_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rred_pkg::RC_W-1:0]   dividend,
    input  logic [rred_pkg::NCNT_W-1:0] divisor,
    output rred_pkg::mod_stat_t         stat
);
    import rred_pkg::*;

    localparam int BC_W = $clog2(RC_W);

    logic              busy_reg;
    logic              done_reg;
    logic [BC_W-1:0]   bit_cnt_reg;
    logic [RC_W-1:0]   dvd_reg;
    logic [NCNT_W-1:0] dvs_reg;
    logic [NCNT_W-1:0] rem_reg;
    logic [NCNT_W:0]   shifted;
    logic [NCNT_W-1:0] rem_next;

    // One restoring remainder step per cycle
    always_comb begin
        shifted = {rem_reg, dvd_reg[RC_W-1]};
        if (shifted >= {1'b0, dvs_reg}) begin
            rem_next = NCNT_W'(shifted - {1'b0, dvs_reg});
        end else begin
            rem_next = shifted[NCNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
                dvd_reg     <= dividend;
                dvs_reg     <= divisor;
                rem_reg     <= '0;
            end else if (busy_reg) begin
                rem_reg     <= rem_next;
                dvd_reg     <= {dvd_reg[RC_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(RC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg[SLOT_W-1:0];
endmodule

FILE: design/round_robin_event_dispatcher.sv
// Post: result registered the next cycle; posts follow back to back while output is free.
// Dispatch: accept, presence scan (read, check per queue entry), round counter modulo,
//   then per slot step a search (read, check per entry), emit (held while the
//   output is full), tail shift on removal (read, write per entry), advance; then done.
// The shared queue RAM (one read, one write port) paces these steps.
// Reset (aresetn low, synchronous): queue empty, round counter and mask zero, output idle.
module round_robin_event_dispatcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [rred_pkg::SRC_W-1:0]     s_source,
    input  logic [rred_pkg::TAG_WIDTH-1:0] s_event_tag,
    input  logic                           s_callback_valid,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [rred_pkg::SRC_W-1:0]     m_out_source,
    output logic [rred_pkg::TAG_WIDTH-1:0] m_out_tag,
    output logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rred_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_P_RD, ST_P_CHK, ST_MOD_START, ST_MOD_WAIT,
        ST_F_RD, ST_F_CHK, ST_EMIT, ST_C_RD, ST_C_WR, ST_ADV, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [RC_W-1:0]      rc_reg;
    logic [CNT_W-1:0]     q_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [NUM_SOURCES-1:0] present_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 emitted_reg;
    entry_t               hold_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [SRC_W-1:0]     out_src_reg;
    logic [TAG_WIDTH-1:0] out_tag_reg;
    logic                 out_last_reg;

    logic              out_free;
    logic              out_load;
    logic              in_xfer;
    logic              post_ok;
    logic              full;
    logic [NCNT_W-1:0] n_present;
    logic [SRC_W-1:0]  cur_src;
    logic              slot_wrap;
    logic              round_end;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    entry_t            mem_rdata;
    logic              mod_start;
    mod_stat_t         mod_stat;
    logic              cfg_wr;

    // Handshake and status decode
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = s_valid && s_ready;
    assign full      = count_reg >= CNT_W'(QUEUE_DEPTH);
    assign post_ok   = in_xfer && s_kind == KIND_POST && s_callback_valid && !full;
    assign n_present = count_sources(present_reg);
    assign cur_src   = pick_source(present_reg, slot_reg);
    assign slot_wrap = (NCNT_W'(slot_reg) + 1'b1) == n_present;
    // the counter wrapping to zero also closes a round and restarts at slot zero
    assign round_end = slot_wrap || (&rc_reg);
    assign mod_start = (state_reg == ST_MOD_START) && (n_present != '0);
    assign out_load  = (state_reg == ST_IDLE && in_xfer && s_kind == KIND_POST)
                    || ((state_reg == ST_EMIT || state_reg == ST_DONE) && out_free);

    // Queue RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[ADDR_W-1:0];
        mem_wdata = '{src: s_source, tag: s_event_tag};
        if (state_reg == ST_C_WR) begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg[ADDR_W-1:0];
            mem_wdata = mem_rdata;
        end else if (post_ok) begin
            mem_we = 1'b1;
        end
        if (state_reg == ST_C_RD) begin
            mem_raddr = ADDR_W'(idx_reg + 1'b1);
        end else begin
            mem_raddr = q_reg[ADDR_W-1:0];
        end
    end

    rred_queue_ram u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rred_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (rc_reg),
        .divisor  (n_present),
        .stat     (mod_stat)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - MASK_W){1'b0}}, mask_reg};

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            count_reg     <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
            emitted_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                mask_reg <= pwdata[MASK_W-1:0];
            end
            if (out_valid_reg && m_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_kind == KIND_POST) begin
                            out_valid_reg <= 1'b1;
                            out_src_reg   <= s_source;
                            out_tag_reg   <= s_event_tag;
                            out_last_reg  <= 1'b1;
                            if (!s_callback_valid) begin
                                out_status_reg <= STAT_INVALID;
                            end else if (full) begin
                                out_status_reg <= STAT_FULL;
                            end else begin
                                out_status_reg <= STAT_ACCEPTED;
                                count_reg      <= count_reg + 1'b1;
                            end
                        end else begin
                            q_reg       <= '0;
                            present_reg <= '0;
                            state_reg   <= (count_reg == '0) ? ST_DONE : ST_P_RD;
                        end
                    end
                end
                ST_P_RD: begin
                    state_reg <= ST_P_CHK;
                end
                ST_P_CHK: begin
                    // mark registered sources that hold an event
                    if (mask_reg[mem_rdata.src]) begin
                        present_reg[mem_rdata.src] <= 1'b1;
                    end
                    q_reg     <= q_reg + 1'b1;
                    state_reg <= (q_reg + 1'b1 == count_reg) ? ST_MOD_START : ST_P_RD;
                end
                ST_MOD_START: begin
                    state_reg <= (n_present == '0) ? ST_DONE : ST_MOD_WAIT;
                end
                ST_MOD_WAIT: begin
                    if (mod_stat.done) begin
                        slot_reg    <= mod_stat.rem;
                        emitted_reg <= 1'b0;
                        q_reg       <= '0;
                        state_reg   <= ST_F_RD;
                    end
                end
                ST_F_RD: begin
                    state_reg <= ST_F_CHK;
                end
                ST_F_CHK: begin
                    // search oldest event of the slot's source
                    if (mem_rdata.src == cur_src) begin
                        hold_reg  <= mem_rdata;
                        idx_reg   <= q_reg;
                        state_reg <= ST_EMIT;
                    end else begin
                        q_reg     <= q_reg + 1'b1;
                        state_reg <= (q_reg + 1'b1 == count_reg) ? ST_ADV : ST_F_RD;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= STAT_DISPATCHED;
                        out_src_reg    <= hold_reg.src;
                        out_tag_reg    <= hold_reg.tag;
                        out_last_reg   <= 1'b0;
                        emitted_reg    <= 1'b1;
                        if (idx_reg + 1'b1 >= count_reg) begin
                            count_reg <= count_reg - 1'b1;
                            state_reg <= ST_ADV;
                        end else begin
                            state_reg <= ST_C_RD;
                        end
                    end
                end
                ST_C_RD: begin
                    state_reg <= ST_C_WR;
                end
                ST_C_WR: begin
                    // shift the tail down over the removed entry
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg + 2'd2 >= count_reg) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_ADV;
                    end else begin
                        state_reg <= ST_C_RD;
                    end
                end
                ST_ADV: begin
                    rc_reg <= rc_reg + 1'b1;
                    q_reg  <= '0;
                    if (round_end) begin
                        // stop after a round that emitted nothing
                        slot_reg    <= '0;
                        emitted_reg <= 1'b0;
                        state_reg   <= (!emitted_reg || count_reg == '0) ? ST_DONE : ST_F_RD;
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= (count_reg == '0) ? ST_DONE : ST_F_RD;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= STAT_DONE;
                        out_src_reg    <= '0;
                        out_tag_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_out_source = out_src_reg;
    assign m_out_tag    = out_tag_reg;
    assign m_last       = out_last_reg;

`include "round_robin_event_dispatcher_assert.svh"

    `RRED_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RRED_ASSERT_IMPL(a_search_nonempty, aclk, aresetn, state_reg == ST_F_RD, count_reg != '0)
    `RRED_ASSERT_NEXT(a_post_grows, aclk, aresetn, post_ok, count_reg == $past(count_reg) + 1'b1)
endmodule

FILE: tb/round_robin_event_dispatcher_test.sv
module round_robin_event_dispatcher_test;
    import rred_pkg::*;

    typedef struct packed {
        logic                 kind;
        logic [SRC_W-1:0]     source;
        logic [TAG_WIDTH-1:0] tag;
        logic                 cb_valid;
    } event_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [SRC_W-1:0]     source;
        logic [TAG_WIDTH-1:0] tag;
        logic                 last;
    } dispatch_result_t;

    localparam logic [2:0] REG_MASK_ADDR = 3'd0;
    localparam int STALL_PCT = 87;
    localparam int BOTH_PCT = 35;
    localparam int IDLE_LIMIT = 300000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = KIND_POST;
    logic [SRC_W-1:0]     s_source = '0;
    logic [TAG_WIDTH-1:0] s_event_tag = '0;
    logic                 s_callback_valid = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [SRC_W-1:0]     m_out_source;
    logic [TAG_WIDTH-1:0] m_out_tag;
    logic                 m_last;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predictor state
    event_item_t      pending_events[$];
    dispatch_result_t expected_results[$];
    entry_t           event_queue[$];
    logic [31:0]      rr_counter = '0;
    logic [MASK_W-1:0] src_mask = '0;

    event_item_t on_bus;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  sender_pct = 0;
    int  receiver_pct = 0;

    always #10 aclk = ~aclk;

    round_robin_event_dispatcher dut (.*);

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // Append one expected result transfer
    function automatic void expect_result(input dispatch_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Work out the results of one accepted transfer
    function automatic void predict_event(input event_item_t it);
        logic [SRC_W-1:0] present[$];
        logic [NUM_SOURCES-1:0] slot_done;
        logic [31:0] n;
        logic [31:0] slot;
        bit emitted;
        entry_t ent;
        if (it.kind == KIND_POST) begin
            if (!it.cb_valid)
                expect_result({STAT_INVALID, it.source, it.tag, 1'b1});
            else if (event_queue.size() >= QUEUE_DEPTH)
                expect_result({STAT_FULL, it.source, it.tag, 1'b1});
            else begin
                ent = {it.source, it.tag};
                event_queue.insert(event_queue.size(), ent);
                expect_result({STAT_ACCEPTED, it.source, it.tag, 1'b1});
            end
            return;
        end
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (src_mask[i]) begin
                foreach (event_queue[q]) begin
                    if (event_queue[q].src == SRC_W'(i)) begin
                        present.insert(present.size(), SRC_W'(i));
                        break;
                    end
                end
            end
        end
        n = present.size();
        slot_done = '0;
        emitted = 0;
        if (event_queue.size() != 0 && n != 0) begin
            while (event_queue.size() != 0) begin
                slot = rr_counter % n;
                if (!slot_done[slot]) begin
                    foreach (event_queue[q]) begin
                        if (event_queue[q].src == present[slot]) begin
                            expect_result({STAT_DISPATCHED, event_queue[q].src,
                                           event_queue[q].tag, 1'b0});
                            slot_done[slot] = 1'b1;
                            emitted = 1;
                            event_queue.delete(q);
                            break;
                        end
                    end
                end
                rr_counter = rr_counter + 1;
                if (rr_counter % n == 0) begin
                    slot_done = '0;
                    if (!emitted)
                        break;
                    emitted = 0;
                end
            end
        end
        expect_result({STAT_DONE, {SRC_W{1'b0}}, {TAG_WIDTH{1'b0}}, 1'b1});
    endfunction

    // Drive input transfers from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_event(on_bus);
            if (!s_valid || s_ready) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= sender_pct) begin
                    on_bus = pending_events.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= on_bus.kind;
                    s_source <= on_bus.source;
                    s_event_tag <= on_bus.tag;
                    s_callback_valid <= on_bus.cb_valid;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check result transfers and toggle backpressure
    always @(posedge aclk) begin
        dispatch_result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result status=%0d", m_status));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_status !== exp_r.status)
                        report($sformatf("status %0d, want %0d", m_status, exp_r.status));
                    if (m_out_source !== exp_r.source)
                        report($sformatf("source %0d, want %0d", m_out_source, exp_r.source));
                    if (m_out_tag !== exp_r.tag)
                        report($sformatf("tag %h, want %h", m_out_tag, exp_r.tag));
                    if (m_last !== exp_r.last)
                        report($sformatf("last %0d, want %0d", m_last, exp_r.last));
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_mask(input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_MASK_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        src_mask = value[MASK_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic void push_event(input logic kind, input int src,
                                       input int tag, input logic cbv);
        event_item_t it;
        it = {kind, SRC_W'(src), TAG_WIDTH'(tag), cbv};
        pending_events.insert(pending_events.size(), it);
    endfunction

    function automatic void push_random(input int count, input logic [MASK_W-1:0] favor);
        int src;
        int tag;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(7) == 0) begin
                push_event(KIND_DISPATCH, $urandom_range(7), $urandom, $urandom_range(1));
            end else begin
                src = $urandom_range(7);
                if (favor != 0 && $urandom_range(3) != 0)
                    while (!favor[src]) src = $urandom_range(7);
                case ($urandom_range(9))
                    0: tag = 0;
                    1: tag = 16'hFFFF;
                    default: tag = $urandom;
                endcase
                push_event(KIND_POST, src, tag, $urandom_range(9) != 0);
            end
        end
    endfunction

    initial begin
        logic [MASK_W-1:0] masks[6];
        masks = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hA5, 8'h3C};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty dispatch, invalid callback, fill past full, drain
        write_mask(32'hFF);
        push_event(KIND_DISPATCH, 0, 0, 0);
        push_event(KIND_POST, 7, 16'hFFFF, 1'b0);
        for (int k = 0; k < 17; k++)
            push_event(KIND_POST, k % 8, k == 0 ? 0 : 16'hFFFF - k, 1'b1);
        push_event(KIND_POST, 7, 16'h8001, 1'b0);
        push_event(KIND_DISPATCH, 7, 16'hFFFF, 1'b1);
        push_event(KIND_DISPATCH, 0, 0, 0);
        wait_drained();

        // Unregistered sources keep their events queued
        write_mask(32'h0F);
        for (int k = 0; k < 4; k++) push_event(KIND_POST, 4 + k, 16'h1000 + k, 1'b1);
        push_event(KIND_POST, 1, 16'h2222, 1'b1);
        push_event(KIND_DISPATCH, 0, 0, 0);
        wait_drained();

        // Random phases over masks and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            write_mask({24'h0, masks[ph]});
            case (ph % 4)
                0: begin sender_pct = 0; receiver_pct = 0; end
                1: begin sender_pct = STALL_PCT; receiver_pct = 0; end
                2: begin sender_pct = 0; receiver_pct = STALL_PCT; end
                default: begin sender_pct = BOTH_PCT; receiver_pct = BOTH_PCT; end
            endcase
            push_random(22, masks[ph]);
            wait_drained();
        end

        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
